// ----- hw/rtl/md5_pkg.sv -----
// Shared constants, types and round helpers for the MD5 stream hasher.
// No dependencies; imported by md5_compress and md5_stream_hash.
package md5_pkg;

  // Four 32-bit words, index 0 = A in the lowest bits
  typedef logic [3:0][31:0] md5_words_t;

  localparam md5_words_t Md5Iv = {32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] SineRom [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {stage, round[1:0]}
  localparam logic [4:0] RotTab [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  localparam logic [1:0] StageF = 2'd0;
  localparam logic [1:0] StageG = 2'd1;
  localparam logic [1:0] StageH = 2'd2;
  localparam logic [1:0] StageI = 2'd3;

  // Message word used in a given round
  function automatic logic [3:0] md5_msg_idx(input logic [5:0] rnd);
    logic [3:0] q;
    logic [3:0] idx;
    q = rnd[3:0];
    case (rnd[5:4])
      StageF:  idx = q;
      StageG:  idx = 4'((q << 2) + q + 4'd1);
      StageH:  idx = 4'((q << 1) + q + 4'd5);
      StageI:  idx = 4'((q << 3) - q);
      default: idx = q;
    endcase
    return idx;
  endfunction

  function automatic logic [31:0] md5_round_fn(input logic [1:0]  stage,
                                               input logic [31:0] b,
                                               input logic [31:0] c,
                                               input logic [31:0] d);
    logic [31:0] f;
    case (stage)
      StageF:  f = (b & c) | (~b & d);
      StageG:  f = (d & b) | (~d & c);
      StageH:  f = b ^ c ^ d;
      StageI:  f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

// ----- hw/rtl/md5_stream_hash.sv -----
// Streaming MD5: one byte per beat in, one 128-bit digest beat out per message.
// Ordinary byte beats are taken in idle; the 64th byte of a block starts the
// compression unit, which runs one round per cycle (start, 64 rounds, chain add).
// The last beat leads to S_PAD and a compression, plus S_LEN and another one
// when the length needs an extra block, then to S_OUT. Input is ready only in
// idle. Async active-low reset loads the initial vector, clears the length and
// control; the block buffer is not reset. Depends on md5_pkg and md5_compress.
module md5_stream_hash (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic         s_axis_tuser_i,   // [0] has_byte
  input  logic         s_axis_tlast_i,   // last
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o    // word_a, word_b, word_c, word_d
);
  import md5_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state_q;
  logic [2:0]  ret_q;
  md5_words_t  chain_q;
  logic [63:0] count_q;
  logic [31:0] buf_q [16];
  logic        out_valid_q;
  logic [127:0] out_data_q;

  logic        in_beat;
  logic [5:0]  pos;
  logic [3:0]  pos_word;
  logic [1:0]  pos_lane;
  logic        pos_tail;
  logic [63:0] len_bits;
  logic        out_free;
  logic        start;
  logic [3:0]  msg_idx;
  md5_words_t  work;
  logic        cmp_done;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign pos      = count_q[5:0];
  assign pos_word = pos[5:2];
  assign pos_lane = pos[1:0];
  assign pos_tail = (pos[5:3] == 3'b111);   // no room left for the length
  assign len_bits = {count_q[60:0], 3'b000};
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign start = (in_beat && s_axis_tuser_i && (pos == 6'd63)) ||
                 (state_q == S_PAD) || (state_q == S_LEN);

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  md5_compress u_compress (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .chain_i    (chain_q),
    .msg_word_i (buf_q[msg_idx]),
    .msg_idx_o  (msg_idx),
    .work_o     (work),
    .done_o     (cmp_done)
  );

  // Block buffer: byte lanes, pad marker, tail clear and length words
  always_ff @(posedge clk_i) begin
    if (in_beat && s_axis_tuser_i) begin
      if (pos_lane == 2'd0) begin
        buf_q[pos_word] <= {24'd0, s_axis_tdata_i};
      end else begin
        buf_q[pos_word][{pos_lane, 3'b000} +: 8] <= s_axis_tdata_i;
      end
    end
    if (state_q == S_PAD) begin
      if (pos_lane == 2'd0) begin
        buf_q[pos_word] <= 32'h0000_0080;
      end else begin
        buf_q[pos_word][{pos_lane, 3'b000} +: 8] <= 8'h80;
      end
      // length words are left to the branch below when they fit
      for (int i = 0; i < 16; i++) begin
        if ((4'(i) > pos_word) && (pos_tail || (i < 14))) begin
          buf_q[i] <= '0;
        end
      end
      if (!pos_tail) begin
        buf_q[14] <= len_bits[31:0];
        buf_q[15] <= len_bits[63:32];
      end
    end
    if (state_q == S_LEN) begin
      for (int i = 0; i < 14; i++) begin
        buf_q[i] <= '0;
      end
      buf_q[14] <= len_bits[31:0];
      buf_q[15] <= len_bits[63:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      chain_q     <= Md5Iv;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            if (s_axis_tuser_i) begin
              count_q <= count_q + 64'd1;
            end
            if (s_axis_tuser_i && (pos == 6'd63)) begin
              state_q <= S_RND;
              ret_q   <= s_axis_tlast_i ? S_PAD : S_IDLE;
            end else if (s_axis_tlast_i) begin
              state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          state_q <= S_RND;
          ret_q   <= pos_tail ? S_LEN : S_OUT;
        end
        S_LEN: begin
          state_q <= S_RND;
          ret_q   <= S_OUT;
        end
        S_RND: begin
          if (cmp_done) begin
            for (int i = 0; i < 4; i++) begin
              chain_q[i] <= chain_q[i] + work[i];
            end
            state_q <= ret_q;
          end
        end
        S_OUT: begin
          // a held digest is either still waiting or taken this cycle
          if (out_free) begin
            out_data_q  <= chain_q;
            out_valid_q <= 1'b1;
            chain_q     <= Md5Iv;
            count_q     <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/md5_compress.sv -----
// MD5 compression unit: one round per cycle over 64 rounds, shared round adder.
// Depends on md5_pkg (constant ROM, rotate table, round functions).
module md5_compress (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  md5_pkg::md5_words_t chain_i,
  input  logic [31:0]         msg_word_i,
  output logic [3:0]          msg_idx_o,
  output md5_pkg::md5_words_t work_o,
  output logic                done_o
);
  import md5_pkg::*;

  logic [5:0]  round_q;
  logic        busy_q;
  logic        done_q;
  md5_words_t  work_q;

  logic [31:0] f_val;
  logic [31:0] sum;
  logic [4:0]  amt;
  logic [63:0] dbl;
  logic [31:0] new_b;

  always_comb begin
    f_val = md5_round_fn(round_q[5:4], work_q[1], work_q[2], work_q[3]);
    sum   = work_q[0] + f_val + SineRom[round_q] + msg_word_i;
    amt   = RotTab[{round_q[5:4], round_q[1:0]}];
    // rotate left: upper half of the doubled word shifted up
    dbl   = {sum, sum} << amt;
    new_b = work_q[1] + dbl[63:32];
  end

  assign msg_idx_o = md5_msg_idx(round_q);
  assign work_o    = work_q;
  assign done_o    = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      work_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        work_q  <= chain_i;
        round_q <= '0;
        busy_q  <= 1'b1;
      end else if (busy_q) begin
        work_q[0] <= work_q[3];
        work_q[3] <= work_q[2];
        work_q[2] <= work_q[1];
        work_q[1] <= new_b;
        round_q   <= round_q + 6'd1;
        if (round_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- verif/tb_md5_stream_hash.sv -----
// Self-checking testbench for md5_stream_hash: byte stream in, digests out.
// Keeps its own MD5 predictor; needs md5_pkg and the RTL of md5_stream_hash.
module tb_md5_stream_hash;
  timeunit 1ns;
  timeprecision 1ps;

  import md5_pkg::md5_words_t;

  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned RandBeats   = 1300;
  localparam int unsigned PhaseLen    = 160;
  localparam int unsigned HoldStart   = 700;
  localparam int unsigned HoldCycles  = 600;

  localparam logic [1:0] PhaseFree = 2'd0;
  localparam logic [1:0] PhaseSend = 2'd1;
  localparam logic [1:0] PhaseRecv = 2'd2;
  localparam logic [1:0] PhaseBoth = 2'd3;

  localparam logic [1:0] StepF = 2'd0;
  localparam logic [1:0] StepG = 2'd1;
  localparam logic [1:0] StepH = 2'd2;

  localparam logic [31:0] RoundConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam int unsigned RotAmt [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                          4, 11, 16, 23, 6, 10, 15, 21};
  localparam int unsigned WordStep [4] = '{1, 5, 3, 7};
  localparam int unsigned WordBase [4] = '{0, 1, 5, 0};
  localparam md5_words_t InitChain = {32'h10325476, 32'h98badcfe,
                                      32'hefcdab89, 32'h67452301};
  localparam int unsigned EdgeLen [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } byte_beat_t;

  logic         clk_i    = 1'b0;
  logic         rst_ni   = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [7:0]   s_tdata  = '0;
  logic         s_tuser  = 1'b0;
  logic         s_tlast  = 1'b0;
  logic         m_tready = 1'b0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [127:0] m_axis_tdata_o;

  byte_beat_t  pending_beats [$];
  md5_words_t  digest_q [$];
  md5_words_t  chain_w;
  logic [31:0] blk_w [16];
  logic [63:0] msg_bytes;
  md5_words_t  seen_digest;
  md5_words_t  want_digest;

  int unsigned rst_cnt     = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned beats_taken = 0;
  int unsigned err_cnt     = 0;
  int unsigned hold_left   = 0;
  logic        hold_done   = 1'b0;
  logic [1:0]  idle_phase;

  assign idle_phase = 2'((beats_taken / PhaseLen) % 4);

  md5_stream_hash i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_cnt < 12) begin
      rst_cnt <= rst_cnt + 1;
    end else begin
      rst_ni <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic fold_block();
    logic [31:0] a, b, c, d, f, sum, tmp;
    logic [1:0]  st;
    int unsigned q, g;
    a = chain_w[0];
    b = chain_w[1];
    c = chain_w[2];
    d = chain_w[3];
    for (int r = 0; r < 64; r++) begin
      st = 2'(r / 16);
      q  = r % 16;
      case (st)
        StepF:   f = (b & c) | (~b & d);
        StepG:   f = (d & b) | (~d & c);
        StepH:   f = b ^ c ^ d;
        default: f = c ^ (b | ~d);
      endcase
      g   = (WordStep[st] * q + WordBase[st]) % 16;
      sum = a + f + RoundConst[r] + blk_w[g];
      tmp = d;
      d   = c;
      c   = b;
      b   = b + rotl32(sum, RotAmt[st * 4 + q % 4]);
      a   = tmp;
    end
    chain_w[0] = chain_w[0] + a;
    chain_w[1] = chain_w[1] + b;
    chain_w[2] = chain_w[2] + c;
    chain_w[3] = chain_w[3] + d;
  endtask

  // little-endian lanes; lane 0 clears the word first
  task automatic place_byte(input int unsigned pos, input logic [7:0] val);
    if (pos % 4 == 0) blk_w[pos / 4] = '0;
    blk_w[pos / 4][(pos % 4) * 8 +: 8] = val;
  endtask

  task automatic absorb_beat(input byte_beat_t bt);
    int unsigned pos;
    logic [63:0] bit_len;
    if (bt.has) begin
      pos = msg_bytes[5:0];
      place_byte(pos, bt.data);
      msg_bytes = msg_bytes + 1;
      if (pos == 63) fold_block();
    end
    if (bt.last) begin
      pos = msg_bytes[5:0];
      place_byte(pos, 8'h80);
      for (int w = pos / 4 + 1; w < 16; w++) blk_w[w] = '0;
      // no room left for the length: one more block of padding
      if (pos >= 56) begin
        fold_block();
        for (int w = 0; w < 16; w++) blk_w[w] = '0;
      end
      bit_len   = msg_bytes << 3;
      blk_w[14] = bit_len[31:0];
      blk_w[15] = bit_len[63:32];
      fold_block();
      digest_q.push_back(chain_w);
      chain_w   = InitChain;
      msg_bytes = '0;
    end
  endtask

  // ---------------------------------------------------------------- driver

  function automatic int unsigned send_idle_pct(input logic [1:0] ph);
    case (ph)
      PhaseSend: return 71;
      PhaseBoth: return 29;
      default:   return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct(input logic [1:0] ph);
    case (ph)
      PhaseRecv: return 71;
      PhaseBoth: return 29;
      default:   return 0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_axis_tready_o) begin
        absorb_beat('{data: s_tdata, has: s_tuser, last: s_tlast});
        beats_taken <= beats_taken + 1;
      end
      if (!s_tvalid || s_axis_tready_o) begin
        if (pending_beats.size() != 0 &&
            $urandom_range(0, 99) >= send_idle_pct(idle_phase)) begin
          {s_tdata, s_tuser, s_tlast} <= pending_beats.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic check_word(input string field, input logic [31:0] got,
                            input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", field, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_tready) begin
        seen_digest = m_axis_tdata_o;
        if (digest_q.size() == 0) begin
          report_mismatch($sformatf("digest %h with none pending", m_axis_tdata_o));
        end else begin
          want_digest = digest_q.pop_front();
          check_word("word_a", seen_digest[0], want_digest[0]);
          check_word("word_b", seen_digest[1], want_digest[1]);
          check_word("word_c", seen_digest[2], want_digest[2]);
          check_word("word_d", seen_digest[3], want_digest[3]);
        end
      end
      // one long hold-off so the block backs up onto its input
      if (!hold_done && beats_taken >= HoldStart) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct(idle_phase));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic add_beat(input logic [7:0] data, input logic has, input logic last);
    pending_beats.push_back('{data: data, has: has, last: last});
  endtask

  initial begin
    int unsigned counted;
    int unsigned len;
    logic        join_last;
    chain_w   = InitChain;
    msg_bytes = '0;
    for (int w = 0; w < 16; w++) blk_w[w] = '0;

    // empty message, then an ignored beat
    add_beat(8'h00, 1'b0, 1'b1);
    add_beat(8'hff, 1'b0, 1'b0);
    // single byte carrying the end flag
    add_beat(8'h00, 1'b1, 1'b1);
    // byte extremes, end flag on its own beat
    add_beat(8'hff, 1'b1, 1'b0);
    add_beat(8'h80, 1'b1, 1'b0);
    add_beat(8'h01, 1'b1, 1'b0);
    add_beat(8'h7f, 1'b1, 1'b0);
    add_beat(8'h3c, 1'b0, 1'b1);
    // ignored beat inside a message
    add_beat(8'haa, 1'b1, 1'b0);
    add_beat(8'hff, 1'b0, 1'b0);
    add_beat(8'h55, 1'b1, 1'b1);
    add_beat(8'h61, 1'b1, 1'b0);
    add_beat(8'h62, 1'b1, 1'b0);
    add_beat(8'h63, 1'b1, 1'b1);

    counted = 0;
    while (counted < RandBeats) begin
      if ($urandom_range(0, 9) < 3) len = EdgeLen[$urandom_range(0, 9)];
      else len = $urandom_range(0, 40);
      join_last = (len != 0) && $urandom_range(0, 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) add_beat(8'($urandom), 1'b0, 1'b0);
        add_beat(8'($urandom), 1'b1, join_last && (i == len - 1));
      end
      if (!join_last) add_beat(8'($urandom), 1'b0, 1'b1);
      counted += len + (join_last ? 0 : 1);
    end

    while (pending_beats.size() != 0 || s_tvalid) @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- md5_stream_hash.f -----
hw/rtl/md5_pkg.sv
hw/rtl/md5_compress.sv
hw/rtl/md5_stream_hash.sv
verif/tb_md5_stream_hash.sv
